/* rtl/core/dsva_pkg.sv */
// Shared constants, register map and controller/datapath link types for the
// depth slice averaging block. No dependencies.

package dsva_pkg;

	// Default sizing of the top level.
	localparam int DEF_MAX_SLICES = 32;
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 512;

	// Field widths.
	localparam int PIX_W   = 8;
	localparam int IDX_W   = 5;
	localparam int RANGE_W = 12;
	localparam int FRAC_W  = 4;

	// Register widths.
	localparam int LIMIT_W = 8;
	localparam int IMGW_W  = 11;
	localparam int SLW_W   = 11;
	localparam int SLH_W   = 10;
	localparam int SLN_W   = 6;

	// Width used for position compares; covers every register and size limit.
	localparam int CMP_W = 13;

	// Register port.
	localparam int PADDR_W   = 5;
	localparam int PDATA_W   = 32;
	localparam int REG_IDX_W = PADDR_W - 2;

	localparam logic [REG_IDX_W-1:0] REG_RANGE_LIMIT  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_SLICE_WIDTH  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_SLICE_HEIGHT = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_SLICE_COUNT  = 3'd4;

	localparam logic [LIMIT_W-1:0] RST_RANGE_LIMIT  = 8'd255;
	localparam logic [IMGW_W-1:0]  RST_IMAGE_WIDTH  = 11'd320;
	localparam logic [SLW_W-1:0]   RST_SLICE_WIDTH  = 11'd16;
	localparam logic [SLH_W-1:0]   RST_SLICE_HEIGHT = 10'd240;
	localparam logic [SLN_W-1:0]   RST_SLICE_COUNT  = 6'd16;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch_pix;  // take the pixel; clear the frame when it is flagged
		logic rd_pos;     // read the entry of the current slice
		logic acc;        // accumulate the pixel and advance the position
		logic k_clr;      // restart the readout index
		logic rd_k;       // read the entry at the readout index
		logic div_avg;    // load the divider with sum*16 / count
		logic div_pos;    // load the divider with column / slice width
		logic div_step;   // one restoring division step
		logic pos_apply;  // take slice and offset from the divider
		logic out_load;   // load the output register
		logic k_inc;      // next readout index
	} dsva_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic band_done;
		logic band_end;
		logic cnt_zero;
		logic div_done;
		logic last_k;
		logic out_free;
	} dsva_stat_t;

endpackage

/* rtl/core/dsva_pix_if.sv */
// Pixel stream channel: valid/ready handshake with pixel payload.
// Depends on dsva_pkg.

interface dsva_pix_if;
	import dsva_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel;
	logic             frame_start;

	modport source (output valid, output pixel, output frame_start, input ready);
	modport sink (input valid, input pixel, input frame_start, output ready);
endinterface

/* rtl/core/dsva_res_if.sv */
// Slice result channel: valid/ready handshake with one range per transfer.
// Depends on dsva_pkg.

interface dsva_res_if;
	import dsva_pkg::*;

	logic               valid;
	logic               ready;
	logic [IDX_W-1:0]   slice_index;
	logic [RANGE_W-1:0] range_value;
	logic               no_data;
	logic               last;

	modport source (output valid, output slice_index, output range_value,
		output no_data, output last, input ready);
	modport sink (input valid, input slice_index, input range_value,
		input no_data, input last, output ready);
endinterface

/* rtl/core/depth_slice_valid_average.sv */
// Pixel handling: each pixel is accepted, its slice entry is read and the entry is written
// back; a pixel after the band is finished and without a frame start is dropped after the
// accept. A new pixel is taken only once the last one is through, as the read-modify-write
// of the slice memory requires. After the last pixel of the band each slice entry is read
// and checked; a slice with hits is divided in 12 divider steps, and every slice result then
// goes to the output register. A slice width write stalls input until slice and offset are
// recomputed. arst_n clears settings to defaults and all counters.
//
// Top level of the depth slice averaging block. Depends on dsva_pkg, dsva_pix_if,
// dsva_res_if, dsva_cfg, dsva_ctrl and dsva_dp.

module depth_slice_valid_average #(
	parameter int MAX_SLICES = dsva_pkg::DEF_MAX_SLICES,
	parameter int MAX_WIDTH  = dsva_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = dsva_pkg::DEF_MAX_HEIGHT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	dsva_pix_if.sink                     pix,
	dsva_res_if.source                   res,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [dsva_pkg::PADDR_W-1:0] paddr,
	input  logic [dsva_pkg::PDATA_W-1:0] pwdata,
	output logic [dsva_pkg::PDATA_W-1:0] prdata,
	output logic                         pready
);
	import dsva_pkg::*;

	localparam int W_W = $clog2(MAX_WIDTH + 1);
	localparam int H_W = $clog2(MAX_HEIGHT + 1);
	localparam int N_W = $clog2(MAX_SLICES + 1);

	// Settings as the datapath sees them, already saturated to legal ranges.
	logic [LIMIT_W-1:0] limit;
	logic [W_W-1:0]     img_w;
	logic [W_W-1:0]     sl_w;
	logic [H_W-1:0]     sl_h;
	logic [N_W-1:0]     sl_n;

	// A slice width write invalidates the incremental slice/offset counters,
	// so the controller recomputes them from the column before the next pixel.
	logic sw_wr;

	dsva_cmd_t  cmd;
	dsva_stat_t st;

	dsva_cfg #(
		.MAX_SLICES(MAX_SLICES),
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.limit  (limit),
		.img_w  (img_w),
		.sl_w   (sl_w),
		.sl_h   (sl_h),
		.sl_n   (sl_n),
		.sw_wr  (sw_wr)
	);

	// The controller owns the handshake on the pixel side: a pixel transfer
	// happens only in the idle state, and the pixel is then processed over
	// the following cycles while ready stays low.
	dsva_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix_valid(pix.valid),
		.pix_ready(pix.ready),
		.sw_wr    (sw_wr),
		.st       (st),
		.cmd      (cmd)
	);

	// The datapath holds an output register, so a result can wait for its
	// transfer while the next slice is being divided.
	dsva_dp #(
		.MAX_SLICES(MAX_SLICES),
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.st             (st),
		.pixel          (pix.pixel),
		.frame_start    (pix.frame_start),
		.limit          (limit),
		.img_w          (img_w),
		.sl_w           (sl_w),
		.sl_h           (sl_h),
		.sl_n           (sl_n),
		.out_ready      (res.ready),
		.out_valid      (res.valid),
		.out_slice_index(res.slice_index),
		.out_range_value(res.range_value),
		.out_no_data    (res.no_data),
		.out_last       (res.last)
	);

endmodule

/* rtl/core/dsva_cfg.sv */
// APB register file: holds the five settings and presents them clamped.
// Depends on dsva_pkg.

module dsva_cfg #(
	parameter int MAX_SLICES = dsva_pkg::DEF_MAX_SLICES,
	parameter int MAX_WIDTH  = dsva_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = dsva_pkg::DEF_MAX_HEIGHT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [dsva_pkg::PADDR_W-1:0] paddr,
	input  logic [dsva_pkg::PDATA_W-1:0] pwdata,
	output logic [dsva_pkg::PDATA_W-1:0] prdata,
	output logic                         pready,
	output logic [dsva_pkg::LIMIT_W-1:0] limit,
	output logic [$clog2(MAX_WIDTH+1)-1:0]  img_w,
	output logic [$clog2(MAX_WIDTH+1)-1:0]  sl_w,
	output logic [$clog2(MAX_HEIGHT+1)-1:0] sl_h,
	output logic [$clog2(MAX_SLICES+1)-1:0] sl_n,
	output logic                         sw_wr
);
	import dsva_pkg::*;

	localparam int W_W = $clog2(MAX_WIDTH + 1);
	localparam int H_W = $clog2(MAX_HEIGHT + 1);
	localparam int N_W = $clog2(MAX_SLICES + 1);

	logic [LIMIT_W-1:0]   limit_q;
	logic [IMGW_W-1:0]    imgw_q;
	logic [SLW_W-1:0]     slw_q;
	logic [SLH_W-1:0]     slh_q;
	logic [SLN_W-1:0]     sln_q;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign wr_en   = psel & penable & pwrite;
	assign sw_wr   = wr_en && (reg_idx == REG_SLICE_WIDTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= RST_RANGE_LIMIT;
			imgw_q  <= RST_IMAGE_WIDTH;
			slw_q   <= RST_SLICE_WIDTH;
			slh_q   <= RST_SLICE_HEIGHT;
			sln_q   <= RST_SLICE_COUNT;
		end else if (wr_en) begin
			case (reg_idx)
				REG_RANGE_LIMIT:  limit_q <= pwdata[LIMIT_W-1:0];
				REG_IMAGE_WIDTH:  imgw_q  <= pwdata[IMGW_W-1:0];
				REG_SLICE_WIDTH:  slw_q   <= pwdata[SLW_W-1:0];
				REG_SLICE_HEIGHT: slh_q   <= pwdata[SLH_W-1:0];
				REG_SLICE_COUNT:  sln_q   <= pwdata[SLN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_RANGE_LIMIT:  prdata = PDATA_W'(limit_q);
			REG_IMAGE_WIDTH:  prdata = PDATA_W'(imgw_q);
			REG_SLICE_WIDTH:  prdata = PDATA_W'(slw_q);
			REG_SLICE_HEIGHT: prdata = PDATA_W'(slh_q);
			REG_SLICE_COUNT:  prdata = PDATA_W'(sln_q);
			default:          prdata = '0;
		endcase
	end

	// Out-of-range settings saturate into their legal range.
	always_comb begin
		limit = limit_q;
		if (imgw_q == '0)
			img_w = W_W'(1);
		else if (32'(imgw_q) > MAX_WIDTH)
			img_w = W_W'(MAX_WIDTH);
		else
			img_w = W_W'(imgw_q);
		if (slw_q == '0)
			sl_w = W_W'(1);
		else if (32'(slw_q) > MAX_WIDTH)
			sl_w = W_W'(MAX_WIDTH);
		else
			sl_w = W_W'(slw_q);
		if (slh_q == '0)
			sl_h = H_W'(1);
		else if (32'(slh_q) > MAX_HEIGHT)
			sl_h = H_W'(MAX_HEIGHT);
		else
			sl_h = H_W'(slh_q);
		if (sln_q == '0)
			sl_n = N_W'(1);
		else if (32'(sln_q) > MAX_SLICES)
			sl_n = N_W'(MAX_SLICES);
		else
			sl_n = N_W'(sln_q);
	end

endmodule

/* rtl/core/dsva_ctrl.sv */
// Controller state machine: sequences pixel accumulation, band readout and
// slice position recomputation. Depends on dsva_pkg.

module dsva_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pix_valid,
	output logic                 pix_ready,
	input  logic                 sw_wr,
	input  dsva_pkg::dsva_stat_t st,
	output dsva_pkg::dsva_cmd_t  cmd
);
	import dsva_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD   = 3'd1;
	localparam logic [2:0] S_WR   = 3'd2;
	localparam logic [2:0] S_KRD  = 3'd3;
	localparam logic [2:0] S_KCHK = 3'd4;
	localparam logic [2:0] S_DIV  = 3'd5;
	localparam logic [2:0] S_OUT  = 3'd6;
	localparam logic [2:0] S_RDIV = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       rsync_q;

	assign pix_ready = (state_q == S_IDLE) && !rsync_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rsync_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (sw_wr)
				rsync_q <= 1'b1;
			else if (cmd.pos_apply)
				rsync_q <= 1'b0;
		end
	end

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (rsync_q) begin
					cmd.div_pos = 1'b1;
					state_d     = S_RDIV;
				end else if (pix_valid) begin
					cmd.latch_pix = 1'b1;
					state_d       = S_RD;
				end
			end
			S_RD: begin
				if (st.band_done) begin
					state_d = S_IDLE;
				end else begin
					cmd.rd_pos = 1'b1;
					state_d    = S_WR;
				end
			end
			S_WR: begin
				cmd.acc = 1'b1;
				if (st.band_end) begin
					cmd.k_clr = 1'b1;
					state_d   = S_KRD;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_KRD: begin
				cmd.rd_k = 1'b1;
				state_d  = S_KCHK;
			end
			S_KCHK: begin
				if (st.cnt_zero) begin
					state_d = S_OUT;
				end else begin
					cmd.div_avg = 1'b1;
					state_d     = S_DIV;
				end
			end
			S_DIV: begin
				if (st.div_done)
					state_d = S_OUT;
				else
					cmd.div_step = 1'b1;
			end
			S_OUT: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					if (st.last_k) begin
						state_d = S_IDLE;
					end else begin
						cmd.k_inc = 1'b1;
						state_d   = S_KRD;
					end
				end
			end
			S_RDIV: begin
				if (st.div_done) begin
					cmd.pos_apply = 1'b1;
					state_d       = S_IDLE;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

/* rtl/core/dsva_dp.sv */
// Datapath: position counters, per-slice sum/count memory, shared restoring
// divider and output register. Depends on dsva_pkg.

module dsva_dp #(
	parameter int MAX_SLICES = dsva_pkg::DEF_MAX_SLICES,
	parameter int MAX_WIDTH  = dsva_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = dsva_pkg::DEF_MAX_HEIGHT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  dsva_pkg::dsva_cmd_t             cmd,
	output dsva_pkg::dsva_stat_t            st,
	input  logic [dsva_pkg::PIX_W-1:0]      pixel,
	input  logic                            frame_start,
	input  logic [dsva_pkg::LIMIT_W-1:0]    limit,
	input  logic [$clog2(MAX_WIDTH+1)-1:0]  img_w,
	input  logic [$clog2(MAX_WIDTH+1)-1:0]  sl_w,
	input  logic [$clog2(MAX_HEIGHT+1)-1:0] sl_h,
	input  logic [$clog2(MAX_SLICES+1)-1:0] sl_n,
	input  logic                            out_ready,
	output logic                            out_valid,
	output logic [dsva_pkg::IDX_W-1:0]      out_slice_index,
	output logic [dsva_pkg::RANGE_W-1:0]    out_range_value,
	output logic                            out_no_data,
	output logic                            out_last
);
	import dsva_pkg::*;

	localparam int W_W     = $clog2(MAX_WIDTH + 1);
	localparam int COL_W   = $clog2(MAX_WIDTH);
	localparam int ROW_W   = $clog2(MAX_HEIGHT);
	localparam int SLICE_W = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1;
	localparam int CNT_W   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
	localparam int SUM_W   = CNT_W + PIX_W;
	localparam int ENT_W   = SUM_W + CNT_W;
	localparam int DVD_W   = (COL_W > RANGE_W) ? COL_W : RANGE_W;
	localparam int REM_W   = (CNT_W > W_W) ? CNT_W : W_W;
	localparam int STEP_W  = $clog2(DVD_W + 1);
	localparam int SHR     = RANGE_W - FRAC_W;

	// Position and frame state.
	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;
	logic [COL_W-1:0]   slc_q;
	logic [COL_W-1:0]   off_q;
	logic               band_done_q;
	logic [PIX_W-1:0]   pix_q;
	logic [SLICE_W-1:0] k_q;

	// Slice accumulators; an entry without its valid bit reads as zero.
	logic [ENT_W-1:0]      acc_mem [MAX_SLICES];
	logic [MAX_SLICES-1:0] vld_q;
	logic [ENT_W-1:0]      rd_ent_q;
	logic                  rd_vld_q;

	// Divider.
	logic [REM_W-1:0]  rem_q;
	logic [REM_W-1:0]  dvs_q;
	logic [DVD_W-1:0]  dvd_q;
	logic [DVD_W-1:0]  quo_q;
	logic [STEP_W-1:0] step_q;

	// Output register.
	logic               out_valid_q;
	logic [IDX_W-1:0]   out_idx_q;
	logic [RANGE_W-1:0] out_range_q;
	logic               out_nd_q;
	logic               out_last_q;

	logic [ENT_W-1:0]   ent;
	logic [SUM_W-1:0]   ent_sum;
	logic [CNT_W-1:0]   ent_cnt;
	logic [SLICE_W-1:0] mem_idx;
	logic [SLICE_W-1:0] rd_addr;
	logic [COL_W:0]     col_inc;
	logic               row_end;
	logic               row_last;
	logic               off_wrap;
	logic               hit;
	logic [REM_W:0]     div_r2;
	logic [REM_W:0]     div_diff;
	logic               div_ge;

	assign ent     = rd_vld_q ? rd_ent_q : '0;
	assign ent_sum = ent[ENT_W-1:CNT_W];
	assign ent_cnt = ent[CNT_W-1:0];
	assign mem_idx = SLICE_W'(slc_q);
	assign rd_addr = cmd.rd_k ? k_q : mem_idx;

	assign col_inc  = {1'b0, col_q} + (COL_W + 1)'(1);
	assign row_end  = CMP_W'(col_inc) >= CMP_W'(img_w);
	assign row_last = (CMP_W'(row_q) + CMP_W'(1)) >= CMP_W'(sl_h);
	assign off_wrap = (CMP_W'(off_q) + CMP_W'(1)) >= CMP_W'(sl_w);
	assign hit      = (CMP_W'(slc_q) < CMP_W'(sl_n)) && (pix_q != '0) && (pix_q < limit);

	assign div_r2   = {rem_q, dvd_q[DVD_W-1]};
	assign div_diff = div_r2 - {1'b0, dvs_q};
	assign div_ge   = div_r2 >= {1'b0, dvs_q};

	always_comb begin
		st.band_done = band_done_q;
		st.band_end  = row_end && row_last;
		st.cnt_zero  = ent_cnt == '0;
		st.div_done  = step_q == '0;
		st.last_k    = (CMP_W'(k_q) + CMP_W'(1)) == CMP_W'(sl_n);
		st.out_free  = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			slc_q       <= '0;
			off_q       <= '0;
			band_done_q <= 1'b0;
			vld_q       <= '0;
			k_q         <= '0;
		end else begin
			if (cmd.latch_pix && frame_start) begin
				col_q       <= '0;
				row_q       <= '0;
				slc_q       <= '0;
				off_q       <= '0;
				band_done_q <= 1'b0;
				vld_q       <= '0;
			end
			if (cmd.acc) begin
				if (hit)
					vld_q[mem_idx] <= 1'b1;
				if (!row_end) begin
					col_q <= col_inc[COL_W-1:0];
					if (off_wrap) begin
						off_q <= '0;
						slc_q <= slc_q + COL_W'(1);
					end else begin
						off_q <= off_q + COL_W'(1);
					end
				end else begin
					col_q <= '0;
					off_q <= '0;
					slc_q <= '0;
					if (row_last)
						band_done_q <= 1'b1;
					else
						row_q <= row_q + ROW_W'(1);
				end
			end
			if (cmd.pos_apply) begin
				slc_q <= quo_q[COL_W-1:0];
				off_q <= rem_q[COL_W-1:0];
			end
			if (cmd.k_clr)
				k_q <= '0;
			else if (cmd.k_inc)
				k_q <= k_q + SLICE_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_pix)
			pix_q <= pixel;
		if (cmd.acc && hit)
			acc_mem[mem_idx] <= {ent_sum + SUM_W'(pix_q), ent_cnt + CNT_W'(1)};
		if (cmd.rd_pos || cmd.rd_k) begin
			rd_ent_q <= acc_mem[rd_addr];
			rd_vld_q <= vld_q[rd_addr];
		end
	end

	// Restoring divider. For an average the quotient is known to fit in
	// RANGE_W bits, so the upper dividend bits preload the remainder.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd.div_avg || cmd.div_pos) begin
			step_q <= cmd.div_avg ? STEP_W'(RANGE_W) : STEP_W'(COL_W);
		end else if (cmd.div_step) begin
			step_q <= step_q - STEP_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_avg) begin
			rem_q <= REM_W'(ent_sum >> SHR);
			dvs_q <= REM_W'(ent_cnt);
			dvd_q <= DVD_W'(RANGE_W'({ent_sum, {FRAC_W{1'b0}}})) << (DVD_W - RANGE_W);
			quo_q <= '0;
		end else if (cmd.div_pos) begin
			rem_q <= '0;
			dvs_q <= REM_W'(sl_w);
			dvd_q <= DVD_W'(col_q) << (DVD_W - COL_W);
			quo_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= div_ge ? div_diff[REM_W-1:0] : div_r2[REM_W-1:0];
			dvd_q <= dvd_q << 1;
			quo_q <= {quo_q[DVD_W-2:0], div_ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_idx_q   <= IDX_W'(k_q);
			out_range_q <= st.cnt_zero ? '0 : quo_q[RANGE_W-1:0];
			out_nd_q    <= st.cnt_zero;
			out_last_q  <= st.last_k;
		end
	end

	assign out_valid       = out_valid_q;
	assign out_slice_index = out_idx_q;
	assign out_range_value = out_range_q;
	assign out_no_data     = out_nd_q;
	assign out_last        = out_last_q;

endmodule

/* rtl/core/dsva_chk.sv */
// Port-level checker for the depth slice averaging block, attached by bind.
// Depends on dsva_pkg and depth_slice_valid_average.

module dsva_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         pix_valid,
	input logic                         pix_ready,
	input logic                         res_valid,
	input logic                         res_ready,
	input logic [dsva_pkg::IDX_W-1:0]   res_slice_index,
	input logic [dsva_pkg::RANGE_W-1:0] res_range_value,
	input logic                         res_no_data,
	input logic                         res_last
);
	import dsva_pkg::*;

	logic [IDX_W-1:0] exp_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			exp_idx_q <= '0;
		else if (res_valid && res_ready)
			exp_idx_q <= res_last ? '0 : exp_idx_q + IDX_W'(1);
	end

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result valid dropped before its transfer");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_slice_index) && $stable(res_range_value)
			&& $stable(res_no_data) && $stable(res_last))
		else $error("stalled result changed");

	a_pix_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_ready |=> !pix_ready)
		else $error("pixel taken while the previous one is in process");

	a_idx_order: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_slice_index == exp_idx_q)
		else $error("slice results out of order");

	a_readout_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_last |-> !pix_ready)
		else $error("pixel input open during band readout");

endmodule

bind depth_slice_valid_average dsva_chk u_dsva_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.pix_valid      (pix.valid),
	.pix_ready      (pix.ready),
	.res_valid      (res.valid),
	.res_ready      (res.ready),
	.res_slice_index(res.slice_index),
	.res_range_value(res.range_value),
	.res_no_data    (res.no_data),
	.res_last       (res.last)
);

/* dv/tb_depth_slice_valid_average.sv */
// Self-checking testbench for depth_slice_valid_average: drives pixel frames and register
// writes, predicts the per-slice ranges and compares every result transfer.
// Depends on dsva_pkg, dsva_pix_if, dsva_res_if and the RTL of the block.

module tb_depth_slice_valid_average;
	import dsva_pkg::*;

	localparam int HALF_PERIOD   = 5;
	// Cycles to wait before a register write once no result is pending. A pixel that
	// produces no result passes only through the accept, read and write-back states, so this leaves a wide margin.
	localparam int SETTLE_CYCLES = 12;
	// Quiet cycles at the end so that any stray result transfer is still seen.
	localparam int DRAIN_CYCLES  = 60;
	// A bound far above any correct run, even if every pixel closed a band of 32 slices
	// under the longest stalls.
	localparam int TIME_LIMIT    = 50_000_000;
	localparam int RANDOM_ITEMS  = 360;
	// The last pixels of the random test run with no idling on either side.
	localparam int CALM_ITEMS    = 60;

	// One expected slice result, laid out like the result channel.
	typedef struct packed {
		logic [IDX_W-1:0]   slice_index;
		logic [RANGE_W-1:0] range_value;
		logic               no_data;
		logic               last;
	} slice_range_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	dsva_pix_if pixel_bus ();
	dsva_res_if range_bus ();

	depth_slice_valid_average i_dut (
		.clk,
		.arst_n,
		.pix     (pixel_bus),
		.res     (range_bus),
		.psel,
		.penable,
		.pwrite,
		.paddr,
		.pwdata,
		.prdata,
		.pready
	);

	always #HALF_PERIOD clk = ~clk;

	// Our copy of the configuration registers, as stored (not yet saturated).
	logic [LIMIT_W-1:0] cfg_limit;
	logic [IMGW_W-1:0]  cfg_image_w;
	logic [SLW_W-1:0]   cfg_slice_w;
	logic [SLH_W-1:0]   cfg_band_h;
	logic [SLN_W-1:0]   cfg_slices;

	// Our copy of the frame state: raster position, per-slice sums and hit counts.
	int unsigned        col_pos;
	int unsigned        row_pos;
	longint unsigned    slice_sum [DEF_MAX_SLICES];
	int unsigned        slice_hits [DEF_MAX_SLICES];
	bit                 band_finished;

	// Slice results that have been predicted and not yet seen on the result channel.
	slice_range_t       pending_slices [$];

	int                 fail_count = 0;
	// Pixels that the block actually takes into account; ignored pixels do not count.
	int                 pixels_used = 0;
	// When set, both sides of the block idle in random bursts.
	bit                 gaps_on = 1'b0;
	int                 stall_left = 0;

	function automatic int unsigned clip_size(int unsigned v, int unsigned hi);
		if (v < 1)
			return 1;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function void clear_frame();
		foreach (slice_sum[i]) begin
			slice_sum[i] = 0;
			slice_hits[i] = 0;
		end
		col_pos = 0;
		row_pos = 0;
		band_finished = 1'b0;
	endfunction

	function void reset_model();
		cfg_limit   = RST_RANGE_LIMIT;
		cfg_image_w = RST_IMAGE_WIDTH;
		cfg_slice_w = RST_SLICE_WIDTH;
		cfg_band_h  = RST_SLICE_HEIGHT;
		cfg_slices  = RST_SLICE_COUNT;
		clear_frame();
	endfunction

	// Value that a read of a register must return.
	function logic [PDATA_W-1:0] register_value(input logic [REG_IDX_W-1:0] idx);
		case (idx)
			REG_RANGE_LIMIT:  return PDATA_W'(cfg_limit);
			REG_IMAGE_WIDTH:  return PDATA_W'(cfg_image_w);
			REG_SLICE_WIDTH:  return PDATA_W'(cfg_slice_w);
			REG_SLICE_HEIGHT: return PDATA_W'(cfg_band_h);
			REG_SLICE_COUNT:  return PDATA_W'(cfg_slices);
			default:          return '0;
		endcase
	endfunction

	// Predicts the effect of one accepted pixel. Sizes are saturated at use, so a register
	// written mid-frame takes effect on the very next pixel. When the pixel closes the band,
	// one result per slice is queued, left to right.
	function void predict_pixel(input logic [PIX_W-1:0] value, input logic start);
		int unsigned  w;
		int unsigned  sw;
		int unsigned  h;
		int unsigned  n;
		int unsigned  s;
		slice_range_t r;

		w  = clip_size(32'(cfg_image_w), DEF_MAX_WIDTH);
		sw = clip_size(32'(cfg_slice_w), DEF_MAX_WIDTH);
		h  = clip_size(32'(cfg_band_h), DEF_MAX_HEIGHT);
		n  = clip_size(32'(cfg_slices), DEF_MAX_SLICES);

		if (start)
			clear_frame();
		if (band_finished)
			return;
		pixels_used++;

		// Columns past the last slice fall into no slice.
		s = col_pos / sw;
		if (s < n && value != 0 && value < cfg_limit) begin
			slice_sum[s] += value;
			slice_hits[s]++;
		end

		if (col_pos + 1 < w) begin
			col_pos++;
			return;
		end
		col_pos = 0;
		if (row_pos + 1 < h) begin
			row_pos++;
			return;
		end

		band_finished = 1'b1;
		for (int k = 0; k < n; k++) begin
			r.slice_index = IDX_W'(k);
			r.no_data     = (slice_hits[k] == 0);
			r.range_value = r.no_data ? '0 : RANGE_W'((slice_sum[k] * 16) / slice_hits[k]);
			r.last        = (k + 1 == n);
			pending_slices.push_back(r);
		end
	endfunction

	function void note_failure(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%s", msg);
	endfunction

	// A pixel drawn so that invalid, excluded, boundary and valid values all come up often.
	function logic [PIX_W-1:0] random_pixel();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2:       return cfg_limit;
			3:       return PIX_W'($urandom);
			default: return (cfg_limit > 1) ? PIX_W'($urandom_range(1, cfg_limit - 1))
				: PIX_W'($urandom);
		endcase
	endfunction

	// Reads a register over the configuration port and compares it with our copy.
	task automatic check_register(input logic [REG_IDX_W-1:0] idx);
		logic [PDATA_W-1:0] data;

		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		data = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (data !== register_value(idx))
			note_failure($sformatf("register %0d read: expected %0d, got %0d",
				idx, register_value(idx), data));
	endtask

	// Writes a register, updates our copy at the write edge and reads the value back.
	task automatic write_register(input logic [REG_IDX_W-1:0] idx,
		input logic [PDATA_W-1:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (idx)
			REG_RANGE_LIMIT:  cfg_limit   = value[LIMIT_W-1:0];
			REG_IMAGE_WIDTH:  cfg_image_w = value[IMGW_W-1:0];
			REG_SLICE_WIDTH:  cfg_slice_w = value[SLW_W-1:0];
			REG_SLICE_HEIGHT: cfg_band_h  = value[SLH_W-1:0];
			REG_SLICE_COUNT:  cfg_slices  = value[SLN_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		check_register(idx);
	endtask

	task automatic configure(input int limit, input int image_w, input int slice_w,
		input int band_h, input int slices);
		write_register(REG_RANGE_LIMIT, limit);
		write_register(REG_IMAGE_WIDTH, image_w);
		write_register(REG_SLICE_WIDTH, slice_w);
		write_register(REG_SLICE_HEIGHT, band_h);
		write_register(REG_SLICE_COUNT, slices);
	endtask

	// Drops the pixel valid, waits for every predicted result and then lets the block finish
	// any pixel still in flight, so that a register can be written safely.
	task automatic settle();
		@(negedge clk);
		pixel_bus.valid <= 1'b0;
		while (pending_slices.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	// Sends one pixel. The valid stays high after the transfer: the next call either moves
	// it to the next pixel or lowers it at the following falling edge, so the valid never
	// gets two assignments in one time step.
	task automatic send_pixel(input logic [PIX_W-1:0] value, input logic start);
		int gap;

		@(negedge clk);
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 7);
			pixel_bus.valid <= 1'b0;
			pixel_bus.pixel <= PIX_W'($urandom);
			repeat (gap)
				@(negedge clk);
		end
		pixel_bus.valid       <= 1'b1;
		pixel_bus.pixel       <= value;
		pixel_bus.frame_start <= start;
		@(posedge clk);
		while (!pixel_bus.ready)
			@(posedge clk);
		predict_pixel(value, start);
	endtask

	// Sends random pixels until the band is closed. With start low and the band already
	// closed, the single pixel sent is simply ignored by the block.
	task automatic send_band(input logic start);
		send_pixel(random_pixel(), start);
		while (!band_finished)
			send_pixel(random_pixel(), 1'b0);
	endtask

	// Registers must read back their reset values.
	task automatic test_register_reset();
		check_register(REG_RANGE_LIMIT);
		check_register(REG_IMAGE_WIDTH);
		check_register(REG_SLICE_WIDTH);
		check_register(REG_SLICE_HEIGHT);
		check_register(REG_SLICE_COUNT);
	endtask

	// A fixed band with zero pixels, pixels at and above the limit, the smallest valid
	// pixel, an empty slice and a column outside every slice (seven columns, three slices
	// of two). The two pixels after the band must be ignored.
	task automatic test_pixel_extremes();
		logic [PIX_W-1:0] band [14] = '{8'd0, 8'd255, 8'd200, 8'd199, 8'd1, 8'd254, 8'd77,
			8'd0, 8'd0, 8'd128, 8'd64, 8'd3, 8'd200, 8'd5};

		gaps_on = 1'b1;
		configure(200, 7, 2, 2, 3);
		foreach (band[i])
			send_pixel(band[i], i == 0);
		send_pixel(8'h80, 1'b0);
		send_pixel(8'h7f, 1'b0);
		settle();
	endtask

	// Frame starts in the middle of a band, right after a band, and on a pixel that is
	// itself the whole band.
	task automatic test_frame_restart();
		configure(255, 4, 2, 3, 2);
		send_pixel(random_pixel(), 1'b1);
		repeat (4)
			send_pixel(random_pixel(), 1'b0);
		send_band(1'b1);
		send_band(1'b1);
		settle();
		configure(255, 1, 1, 1, 1);
		send_pixel(8'h55, 1'b1);
		send_pixel(8'haa, 1'b0);
		send_pixel(8'h11, 1'b1);
		settle();
	endtask

	// With a limit of zero or one no pixel can be valid, so every slice reports no data.
	task automatic test_low_limit();
		configure(0, 5, 2, 2, 3);
		send_band(1'b1);
		settle();
		write_register(REG_RANGE_LIMIT, 1);
		send_band(1'b1);
		settle();
	endtask

	// Sizes at and beyond their limits. Zero sizes act as one, and an oversized slice
	// width or slice count is clipped; the largest number of slices is covered as well.
	task automatic test_size_limits();
		configure(255, 0, 0, 0, 0);
		send_band(1'b1);
		settle();
		configure(128, 9, 2047, 2, 63);
		send_band(1'b1);
		settle();
		configure(255, 12, 1, 1, 40);
		send_band(1'b1);
		settle();
	endtask

	// Registers written in the middle of a frame. After eight pixels of a six-column
	// frame the position is column two of row one; shrinking the width to three makes
	// that column close the row. Later the band height drops below the current row, so
	// the end of that row closes the band, with a new slice layout and limit in force.
	task automatic test_midframe_change();
		configure(255, 6, 2, 4, 3);
		send_pixel(random_pixel(), 1'b1);
		repeat (7)
			send_pixel(random_pixel(), 1'b0);
		settle();
		write_register(REG_IMAGE_WIDTH, 3);
		repeat (4)
			send_pixel(random_pixel(), 1'b0);
		settle();
		write_register(REG_SLICE_WIDTH, 1);
		write_register(REG_SLICE_COUNT, 4);
		write_register(REG_SLICE_HEIGHT, 2);
		write_register(REG_RANGE_LIMIT, 100);
		send_band(1'b0);
		settle();
	endtask

	// Random small frames under random settings. Most frames are complete; some are cut
	// short by the next frame start and some are followed by pixels that must be ignored.
	task automatic test_random_frames();
		int first_used;
		int image_w;
		int slice_w;
		int limit;
		int slices;

		first_used = pixels_used;
		while (pixels_used - first_used < RANDOM_ITEMS) begin
			if (pixels_used - first_used >= RANDOM_ITEMS - CALM_ITEMS)
				gaps_on = 1'b0;
			else
				gaps_on = ($urandom_range(0, 3) != 0);

			if ($urandom_range(0, 2) == 0) begin
				settle();
				case ($urandom_range(0, 5))
					0:       limit = 1;
					1:       limit = 255;
					2:       limit = 0;
					default: limit = $urandom_range(2, 254);
				endcase
				image_w = $urandom_range(1, 12);
				slice_w = $urandom_range(1, 5);
				case ($urandom_range(0, 3))
					0:       slices = 32;
					1:       slices = $urandom_range(1, 4);
					default: slices = (image_w + slice_w - 1) / slice_w;
				endcase
				configure(limit, image_w, slice_w, $urandom_range(1, 5), slices);
			end

			case ($urandom_range(0, 7))
				0: begin
					send_pixel(random_pixel(), 1'b1);
					repeat ($urandom_range(0, 4))
						send_pixel(random_pixel(), 1'b0);
				end
				1: begin
					send_band(1'b1);
					repeat ($urandom_range(1, 3))
						send_pixel(random_pixel(), 1'b0);
				end
				default: send_band(1'b1);
			endcase
		end
		gaps_on = 1'b0;
		settle();
	endtask

	// Result side: the ready idles in random bursts while idling is on.
	always @(negedge clk) begin
		if (stall_left == 0 && gaps_on && $urandom_range(0, 5) == 0)
			stall_left = $urandom_range(1, 7);
		if (stall_left != 0) begin
			range_bus.ready <= 1'b0;
			stall_left--;
		end else begin
			range_bus.ready <= 1'b1;
		end
	end

	// Every result transfer is compared with the oldest pending prediction.
	always @(posedge clk) begin
		slice_range_t want;
		slice_range_t got;

		if (arst_n && range_bus.valid && range_bus.ready) begin
			got.slice_index = range_bus.slice_index;
			got.range_value = range_bus.range_value;
			got.no_data     = range_bus.no_data;
			got.last        = range_bus.last;
			if (pending_slices.size() == 0) begin
				note_failure($sformatf("unexpected result: slice %0d range %0d no_data %0b last %0b",
					got.slice_index, got.range_value, got.no_data, got.last));
			end else begin
				want = pending_slices.pop_front();
				if (got.slice_index !== want.slice_index || got.range_value !== want.range_value
					|| got.no_data !== want.no_data || got.last !== want.last)
					note_failure($sformatf({"result mismatch: expected slice %0d range %0d ",
						"no_data %0b last %0b, got slice %0d range %0d no_data %0b last %0b"},
						want.slice_index, want.range_value, want.no_data, want.last,
						got.slice_index, got.range_value, got.no_data, got.last));
			end
		end
	end

	// Main sequence: reset once, then each test in turn, then a quiet drain.
	initial begin
		psel                  = 1'b0;
		penable               = 1'b0;
		pwrite                = 1'b0;
		paddr                 = '0;
		pwdata                = '0;
		pixel_bus.valid       = 1'b0;
		pixel_bus.pixel       = '0;
		pixel_bus.frame_start = 1'b0;
		range_bus.ready       = 1'b0;
		reset_model();

		repeat (3)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_register_reset();
		test_pixel_extremes();
		test_frame_restart();
		test_low_limit();
		test_size_limits();
		test_midframe_change();
		test_random_frames();

		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (pending_slices.size() != 0)
			note_failure($sformatf("%0d slice results never arrived", pending_slices.size()));

		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#(TIME_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

/* depth_slice_valid_average.f */
rtl/core/dsva_pkg.sv
rtl/core/dsva_pix_if.sv
rtl/core/dsva_res_if.sv
rtl/core/dsva_cfg.sv
rtl/core/dsva_ctrl.sv
rtl/core/dsva_dp.sv
rtl/core/depth_slice_valid_average.sv
rtl/core/dsva_chk.sv
dv/tb_depth_slice_valid_average.sv
